[rtl/assert_macros.svh]
// assert_macros.svh: assertion macros for the checker file msm_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MSM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define MSM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/msm_pkg.sv]
// msm_pkg: types, codes and default sizes of the shared-memory stack block.
// No dependencies; msm_if, msm_ctrl, msm_dp, the top level and msm_checker import it.
`default_nettype none

package msm_pkg;

  // default sizes, handed to the top-level parameters
  localparam int ENTRIES_DEF = 64;
  localparam int STACKS_DEF  = 4;

  // fixed field widths
  localparam int SEL_W  = 2;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } msm_status_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the operation and launch the memory reads
    logic commit;  // apply the update and fill the result register
  } msm_cmd_t;

endpackage

`default_nettype wire

[rtl/msm_if.sv]
// msm_if: valid/ready channel interfaces for operations and results.
// Depends on msm_pkg.
`default_nettype none

interface msm_in_if
  import msm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic        [SEL_W-1:0] stack_select;
  logic signed [VAL_W-1:0] push_value;

  modport source (output valid, output command, output stack_select,
                  output push_value, input ready);
  modport sink   (input valid, input command, input stack_select,
                  input push_value, output ready);
endinterface

interface msm_out_if
  import msm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic        [STAT_W-1:0] status;
  logic signed [VAL_W-1:0]  pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);
endinterface

`default_nettype wire

[rtl/msm_ram.sv]
// msm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module msm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/msm_ctrl.sv]
// msm_ctrl: sequencing state machine and result handshake.
// Depends on msm_pkg.
`default_nettype none

module msm_ctrl
  import msm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output msm_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // take nothing while reset is asserted
  assign in_ready   = (state_r == S_IDLE) && rst_n;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;

  // advance: idle takes an operation, exec waits for a free result slot
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.load) state_nxt = S_EXEC;
      S_EXEC: if (cmd.commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold the result until its transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/msm_dp.sv]
// msm_dp: entry store, free list, stack tops and result registers.
// Depends on msm_pkg and msm_ram.
`default_nettype none

module msm_dp
  import msm_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int STACKS  = STACKS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire msm_cmd_t                cmd,
  input  wire logic                    in_command,
  input  wire logic        [SEL_W-1:0] in_stack_select,
  input  wire logic signed [VAL_W-1:0] in_push_value,
  output logic        [STAT_W-1:0]     out_status,
  output logic signed [VAL_W-1:0]      out_pop_value
);

  localparam int LW  = $clog2(ENTRIES + 1);          // link width, null included
  localparam int IW  = $clog2(ENTRIES);              // entry address width
  localparam int STW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(ENTRIES);

  // list heads; hw_r counts entries ever taken from the never-used tail
  logic [LW-1:0] free_head_r, free_head_nxt;
  logic [LW-1:0] tops_r [STACKS];
  logic [LW-1:0] hw_r, hw_nxt;

  // captured operation
  logic                    cmd_r;
  logic [STW-1:0]          sel_r;
  logic                    sel_ok_r;
  logic signed [VAL_W-1:0] val_r;
  logic [LW-1:0]           idx_r;

  logic [STAT_W-1:0]       status_r;
  logic signed [VAL_W-1:0] pop_value_r;

  // decode the incoming stack number
  logic [STW+SEL_W-1:0] sel_ext;
  logic [STW-1:0]       sel_in;
  logic                 sel_ok_in;
  logic [LW-1:0]        idx_in;

  assign sel_ext   = {{STW{1'b0}}, in_stack_select};
  assign sel_in    = sel_ext[STW-1:0];
  assign sel_ok_in = (sel_ext < (STW+SEL_W)'(STACKS));

  // push works on the free head, pop on the chosen top
  always_comb begin
    if (in_command == CMD_PUSH) begin
      idx_in = free_head_r;
    end else if (sel_ok_in) begin
      idx_in = tops_r[sel_in];
    end else begin
      idx_in = NULL_LINK;
    end
  end

  // capture the operation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= in_command;
      sel_r    <= sel_in;
      sel_ok_r <= sel_ok_in;
      val_r    <= in_push_value;
      idx_r    <= idx_in;
    end
  end

  // entry store
  logic [LW-1:0]    link_q;
  logic [VAL_W-1:0] value_q;
  logic             link_we, value_we;
  logic [LW-1:0]    link_wdata;

  msm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (idx_r[IW-1:0]),
    .wdata (link_wdata),
    .re    (cmd.load),
    .raddr (idx_in[IW-1:0]),
    .rdata (link_q)
  );

  msm_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (idx_r[IW-1:0]),
    .wdata (val_r),
    .re    (cmd.load),
    .raddr (idx_in[IW-1:0]),
    .rdata (value_q)
  );

  // execute the captured operation
  logic          idx_live, is_push, op_ok, fresh;
  logic [LW-1:0] link_rd;
  logic [LW-1:0] top_cur;

  assign idx_live = (idx_r < NULL_LINK);
  assign is_push  = (cmd_r == CMD_PUSH);
  assign op_ok    = sel_ok_r && idx_live;
  assign top_cur  = tops_r[sel_r];
  // an entry never taken has no link in the RAM; its successor is the next entry
  assign fresh    = is_push && (idx_r == hw_r);
  assign link_rd  = fresh ? (idx_r + LW'(1)) : link_q;

  assign link_we    = cmd.commit && op_ok;
  assign value_we   = cmd.commit && op_ok && is_push;
  assign link_wdata = is_push ? top_cur : free_head_r;

  always_comb begin
    free_head_nxt = free_head_r;
    hw_nxt        = hw_r;
    if (cmd.commit && op_ok) begin
      if (is_push) begin
        free_head_nxt = link_rd;
        if (fresh) hw_nxt = hw_r + LW'(1);
      end else begin
        free_head_nxt = idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      hw_r        <= '0;
      for (int i = 0; i < STACKS; i++) begin
        tops_r[i] <= NULL_LINK;
      end
    end else begin
      free_head_r <= free_head_nxt;
      hw_r        <= hw_nxt;
      if (cmd.commit && op_ok) begin
        tops_r[sel_r] <= is_push ? idx_r : link_rd;
      end
    end
  end

  // fill the result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_ok) begin
        status_r    <= ST_OK;
        pop_value_r <= is_push ? '0 : value_q;
      end else begin
        status_r    <= is_push ? ST_OVERFLOW : ST_EMPTY;
        pop_value_r <= '0;
      end
    end
  end

  assign out_status    = status_r;
  assign out_pop_value = pop_value_r;

endmodule

`default_nettype wire

[rtl/multi_stack_shared_memory.sv]
// multi_stack_shared_memory: several stacks sharing one entry store.
// Depends on msm_pkg, msm_if, msm_ctrl, msm_dp and msm_ram.
//
// Usage: each transfer on in_if is one operation: command push or pop on
// stack stack_select, with push_value stored by a push. Each operation gives
// exactly one transfer on out_if: status ok, overflow (push with no free
// entry, or stack number at or above STACKS) or empty (pop of an empty or
// nonexistent stack), and pop_value, the popped value or zero.
// Timing: taking an operation captures it and launches the reads of the
// link and value memories; the update cycle that follows updates the lists
// and loads the result register, from which out_if is driven.
// One operation is in flight at a time: in_if.ready stays low through the
// update cycle, which uses the registered memory read data.
// The next operation may be taken while a result waits in the output
// register; if the receiver still stalls when that one completes, it holds
// in its update cycle until the output register frees.
// Reset (synchronous): in_if.ready low while asserted; afterwards all stacks
// empty, every entry free in order, no result pending. No clearing pass.
`default_nettype none

module multi_stack_shared_memory
  import msm_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int STACKS  = STACKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  msm_in_if.sink    in_if,
  msm_out_if.source out_if
);

  msm_cmd_t cmd;

  msm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  msm_dp #(.ENTRIES(ENTRIES), .STACKS(STACKS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_command      (in_if.command),
    .in_stack_select (in_if.stack_select),
    .in_push_value   (in_if.push_value),
    .out_status      (out_if.status),
    .out_pop_value   (out_if.pop_value)
  );

endmodule

`default_nettype wire

[rtl/msm_checker.sv]
// msm_checker: port-level assertions for multi_stack_shared_memory.
// Depends on msm_pkg and assert_macros.svh; bound to the top level below.
`default_nettype none
`include "assert_macros.svh"

module msm_checker
  import msm_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic       [STAT_W-1:0] out_status,
  input wire logic signed [VAL_W-1:0] out_pop_value
);

  logic                    status_known;
  logic                    out_fail;
  logic                    out_stall;
  logic                    in_xfer;
  logic [STAT_W+VAL_W-1:0] out_data;

  assign status_known = (out_status == ST_OK) || (out_status == ST_OVERFLOW) ||
                        (out_status == ST_EMPTY);
  assign out_fail     = out_valid && (out_status != ST_OK);
  assign out_stall    = out_valid && !out_ready;
  assign in_xfer      = in_valid && in_ready;
  assign out_data     = {out_status, out_pop_value};

  // a result never carries an unused status code
  `MSM_ASSERT(a_status_code, clk, rst_n, out_valid |-> status_known, "bad status code")

  // a failed operation returns zero data
  `MSM_ASSERT(a_fail_zero, clk, rst_n, out_fail |-> out_pop_value == '0, "data on failure")

  // one operation at a time: input closes for the update cycle
  `MSM_ASSERT(a_one_in_flight, clk, rst_n, in_xfer |=> !in_ready, "input open during update")

  // a stalled result holds
  `MSM_ASSERT(a_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_data), "result changed")

  // reset leaves no result pending
  `MSM_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind multi_stack_shared_memory msm_checker u_msm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_status    (out_if.status),
  .out_pop_value (out_if.pop_value)
);

`default_nettype wire
